>>> hdl/fwh_pkg.sv
// Package for the firmware-hub bus master: beat structs, request kinds
// and the fixed LAD nibble codes. No dependencies.
package fwh_pkg;

  // Request kind carried by each input beat
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  // MSIZE codes
  localparam logic [1:0] MSIZE_1B = 2'd0;
  localparam logic [1:0] MSIZE_2B = 2'd1;
  localparam logic [1:0] MSIZE_4B = 2'd2;
  localparam logic [1:0] MSIZE_BAD = 2'd3;

  // LAD nibble codes
  localparam logic [3:0] START_READ  = 4'hD;
  localparam logic [3:0] START_WRITE = 4'hE;
  localparam logic [3:0] TAR_ONES    = 4'hF;
  localparam logic [3:0] LAD_ZERO    = 4'h0;

  // Clock positions inside a bus cycle
  localparam logic [4:0] POS_IDSEL    = 5'd1;
  localparam logic [4:0] POS_ADDR_LO  = 5'd1;
  localparam logic [4:0] POS_RADDR_LO = 5'd2;
  localparam logic [4:0] POS_ADDR_HI  = 5'd8;
  localparam logic [4:0] POS_MSIZE    = 5'd9;
  localparam logic [4:0] POS_TAR      = 5'd10;
  localparam logic [4:0] POS_RSYNC    = 5'd12;
  localparam logic [4:0] POS_DLO      = 5'd13;
  localparam logic [4:0] POS_DHI      = 5'd14;
  localparam logic [4:0] POS_RTAR     = 5'd15;
  localparam logic [4:0] POS_RLAST    = 5'd16;
  localparam logic [4:0] POS_WDATA    = 5'd10;
  localparam logic [4:0] POS_MAX      = 5'd21;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [1:0]  write_size;
    logic [3:0]  lad_in;
  } fwh_in_t;

  typedef struct packed {
    logic [3:0] lad_out;
    logic       lad_drive;
    logic       frame_n;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       sync_error;
    logic       tar_warning;
  } fwh_out_t;

endpackage

>>> hdl/fwh_bus_master_cycle.sv
// Firmware-hub bus master, one beat per bus clock while not stalled, with a two-entry
// result queue. Depends on fwh_pkg.
//
// Usage:
//   Input channel (item_valid / item_stall / item): one beat per bus clock
//   while item_stall is low, carrying the request kind, address, write data, size and sampled LAD.
//   A start request is taken only while no bus cycle is running.
//   Output channel (res_valid / res_stall / res): one result beat per input
//   beat, in order: LAD drive value and enable, frame_n, busy, done, read
//   byte and the sync / turnaround flags.
//   Results are registered. Throughput: one beat per cycle while the input
//   is not stalled, as the phase update between the input handshake and
//   the result register is combinational.
//   Stall: a result register plus one skid entry hold finished results;
//   the input stalls only while both are full, so an input beat is taken
//   in the same cycle that a result is waiting.
//   Reset: synchronous; the bus cycle returns to idle, the read byte and
//   flags clear, and the result queue empties.
module fwh_bus_master_cycle
  import fwh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  fwh_in_t  item,
  output logic     res_valid,
  input  logic     res_stall,
  output fwh_out_t res
);

  // Bus cycle state
  logic [4:0]  phase, phase_next;
  logic        is_write, is_write_next;
  logic [31:0] addr_reg, addr_reg_next;
  logic [31:0] data_reg, data_reg_next;
  logic [1:0]  size_reg, size_reg_next;
  logic [3:0]  nibble_count, nibble_count_next;
  logic [7:0]  read_byte, read_byte_next;
  logic [1:0]  error_flags, error_flags_next;

  // Result queue
  fwh_out_t main_res, skid_res, new_res;
  logic     skid_valid;

  logic push, pop;
  logic start, idle_tick;
  logic [1:0] size_eff;
  logic [3:0] nc_start;
  logic [2:0] addr_idx;
  logic [2:0] data_idx;
  logic [3:0] addr_nib, data_nib;
  logic [4:0] tar_pos, last_pos;

  assign item_stall = skid_valid;
  assign push       = item_valid && !item_stall;
  assign pop        = res_valid && !res_stall;
  assign res        = main_res;

  // Next state and result of one bus clock
  always_comb begin
    start     = (phase == 5'd0) &&
                (item.kind == KIND_READ || item.kind == KIND_WRITE);
    idle_tick = (phase == 5'd0) && !start;
    size_eff  = (item.write_size == MSIZE_BAD) ? MSIZE_4B : item.write_size;
    case (size_eff)
      MSIZE_1B: nc_start = 4'd2;
      MSIZE_2B: nc_start = 4'd4;
      default:  nc_start = 4'd8;
    endcase

    // latch request on the start clock
    if (start) begin
      is_write_next     = (item.kind == KIND_WRITE);
      addr_reg_next     = item.address;
      data_reg_next     = item.write_data;
      size_reg_next     = size_eff;
      nibble_count_next = (item.kind == KIND_WRITE) ? nc_start : 4'd0;
      read_byte_next    = 8'd0;
      error_flags_next  = 2'd0;
    end else begin
      is_write_next     = is_write;
      addr_reg_next     = addr_reg;
      data_reg_next     = data_reg;
      size_reg_next     = size_reg;
      nibble_count_next = nibble_count;
      read_byte_next    = read_byte;
      error_flags_next  = error_flags;
    end

    // address nibble is (8 - phase) mod 8, data nibble (phase - 10) mod 8
    addr_idx = 3'd0 - phase[2:0];
    data_idx = phase[2:0] - POS_WDATA[2:0];
    addr_nib = addr_reg_next[{addr_idx, 2'b00} +: 4];
    data_nib = data_reg_next[{data_idx, 2'b00} +: 4];
    tar_pos  = POS_TAR + {1'b0, nibble_count_next};
    last_pos = is_write_next ? (tar_pos + 5'd3) : POS_RLAST;

    new_res.lad_out   = LAD_ZERO;
    new_res.lad_drive = 1'b0;
    new_res.frame_n   = 1'b1;
    new_res.busy_res  = !idle_tick;
    new_res.done_res  = 1'b0;
    phase_next        = phase;

    if (!idle_tick) begin
      if (!is_write_next) begin
        // read sequence
        if (phase == 5'd0) begin
          new_res.lad_out   = START_READ;
          new_res.lad_drive = 1'b1;
          new_res.frame_n   = 1'b0;
        end else if (phase == POS_IDSEL || phase == POS_MSIZE) begin
          new_res.lad_drive = 1'b1;
        end else if (phase >= POS_RADDR_LO && phase <= POS_ADDR_HI) begin
          new_res.lad_out   = addr_nib;
          new_res.lad_drive = 1'b1;
        end else if (phase == POS_TAR) begin
          new_res.lad_out   = TAR_ONES;
          new_res.lad_drive = 1'b1;
        end else if (phase == POS_RSYNC) begin
          if (item.lad_in != LAD_ZERO) error_flags_next[0] = 1'b1;
        end else if (phase == POS_DLO) begin
          read_byte_next = {4'd0, item.lad_in};
        end else if (phase == POS_DHI) begin
          read_byte_next = {item.lad_in, read_byte_next[3:0]};
        end else if (phase == POS_RTAR) begin
          if (item.lad_in != TAR_ONES) error_flags_next[1] = 1'b1;
        end
      end else begin
        // write sequence
        if (phase == 5'd0) begin
          new_res.lad_out   = START_WRITE;
          new_res.lad_drive = 1'b1;
          new_res.frame_n   = 1'b0;
        end else if (phase >= POS_ADDR_LO && phase <= POS_ADDR_HI) begin
          new_res.lad_out   = addr_nib;
          new_res.lad_drive = 1'b1;
        end else if (phase == POS_MSIZE) begin
          new_res.lad_out   = {2'b00, size_reg_next};
          new_res.lad_drive = 1'b1;
        end else if (phase >= POS_WDATA && phase < tar_pos) begin
          new_res.lad_out   = data_nib;
          new_res.lad_drive = 1'b1;
        end else if (phase == tar_pos) begin
          new_res.lad_out   = TAR_ONES;
          new_res.lad_drive = 1'b1;
        end else if (phase == tar_pos + 5'd2) begin
          if (item.lad_in != LAD_ZERO) error_flags_next[0] = 1'b1;
        end else if (phase == tar_pos + 5'd3) begin
          if (item.lad_in != TAR_ONES) error_flags_next[1] = 1'b1;
        end
      end
      // end of cycle
      if (phase >= last_pos) begin
        new_res.done_res = 1'b1;
        phase_next       = 5'd0;
      end else begin
        phase_next = phase + 5'd1;
      end
    end

    new_res.read_data   = read_byte_next;
    new_res.sync_error  = error_flags_next[0];
    new_res.tar_warning = error_flags_next[1];
  end

  // Bus cycle state registers, advance once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 5'd0;
      is_write     <= 1'b0;
      addr_reg     <= '0;
      data_reg     <= '0;
      size_reg     <= 2'd0;
      nibble_count <= 4'd0;
      read_byte    <= 8'd0;
      error_flags  <= 2'd0;
    end else if (push) begin
      phase        <= phase_next;
      is_write     <= is_write_next;
      addr_reg     <= addr_reg_next;
      data_reg     <= data_reg_next;
      size_reg     <= size_reg_next;
      nibble_count <= nibble_count_next;
      read_byte    <= read_byte_next;
      error_flags  <= error_flags_next;
    end
  end

  // Result register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!res_valid || pop) begin
        main_res  <= new_res;
        res_valid <= 1'b1;
      end else begin
        skid_res   <= new_res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // skid entry is only used behind a full result register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry valid with empty result register");

  // a beat arriving at a stalled full result register lands in the skid entry
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (push && res_valid && res_stall) |=> skid_valid)
    else $error("result beat dropped");

  // phase stays within the longest write cycle
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= POS_MAX)
    else $error("phase out of range");

  // frame strobe only on a driven start clock of a running cycle
  a_frame: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.frame_n) |-> (res.lad_drive && res.busy_res && !res.done_res))
    else $error("frame strobe outside a start clock");

  // done closes the cycle: the state returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (push && new_res.done_res) |=> (phase == 5'd0))
    else $error("phase not idle after done");
`endif

endmodule
